>>> sv/clsc_pkg.sv
// Shared constants, register and mode codes, and the coil drive struct
// for the closed-loop stepper commutator. No dependencies.
package clsc_pkg;

  // Sensor and position scaling
  localparam int SENSOR_BITS_DEF = 14;
  localparam int TURN_USTEPS     = 200 * 256;
  localparam int HALF_TURN       = 100 * 256;
  localparam int QUARTER_TURN    = 50 * 256;
  localparam int MAX_LEAD        = 256;
  localparam int CUR_W           = 16;
  localparam int CLAMP_W         = 14;

  // Electrical angle and sine table geometry
  localparam int SINE_ENTRIES = 1024;
  localparam int ANGLE_W      = $clog2(SINE_ENTRIES);
  localparam int SINE_QUARTER = SINE_ENTRIES / 4;
  localparam int Q_SHIFT      = 15;
  localparam int MAG_W        = 15;

  // Drive amplitude
  localparam int AMP_W = 13;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_POS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_OFS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_CURRENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MAX    = 3'd5;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_HOLD = 2'd2;

  // Drive for one coil: direction and current magnitude
  typedef struct packed {
    logic             positive;
    logic [AMP_W-1:0] level;
  } phase_drive_t;

endpackage

>>> sv/clsc_coil_pair.sv
// Sine lookup and amplitude scaling for both coils, three register stages.
// Depends on clsc_pkg.
module clsc_coil_pair (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [clsc_pkg::ANGLE_W-1:0] angle_i,
  input  logic [clsc_pkg::AMP_W-1:0] umax_i,
  output logic                       valid_o,
  output clsc_pkg::phase_drive_t     phase_a_o,
  output clsc_pkg::phase_drive_t     phase_b_o
);
  import clsc_pkg::*;

  localparam int PROD_W = AMP_W + MAG_W;
  localparam int HALF_W = ANGLE_W - 1;

  localparam logic [MAG_W-1:0] QuarterSine [257] = '{
    15'd0, 15'd201, 15'd402, 15'd603, 15'd804, 15'd1005, 15'd1206, 15'd1407,
    15'd1608, 15'd1809, 15'd2009, 15'd2210, 15'd2410, 15'd2611, 15'd2811, 15'd3012,
    15'd3212, 15'd3412, 15'd3612, 15'd3811, 15'd4011, 15'd4210, 15'd4410, 15'd4609,
    15'd4808, 15'd5007, 15'd5205, 15'd5404, 15'd5602, 15'd5800, 15'd5998, 15'd6195,
    15'd6393, 15'd6590, 15'd6786, 15'd6983, 15'd7179, 15'd7375, 15'd7571, 15'd7767,
    15'd7962, 15'd8157, 15'd8351, 15'd8545, 15'd8739, 15'd8933, 15'd9126, 15'd9319,
    15'd9512, 15'd9704, 15'd9896, 15'd10087, 15'd10278, 15'd10469, 15'd10659, 15'd10849,
    15'd11039, 15'd11228, 15'd11417, 15'd11605, 15'd11793, 15'd11980, 15'd12167, 15'd12353,
    15'd12539, 15'd12725, 15'd12910, 15'd13094, 15'd13279, 15'd13462, 15'd13645, 15'd13828,
    15'd14010, 15'd14191, 15'd14372, 15'd14553, 15'd14732, 15'd14912, 15'd15090, 15'd15269,
    15'd15446, 15'd15623, 15'd15800, 15'd15976, 15'd16151, 15'd16325, 15'd16499, 15'd16673,
    15'd16846, 15'd17018, 15'd17189, 15'd17360, 15'd17530, 15'd17700, 15'd17869, 15'd18037,
    15'd18204, 15'd18371, 15'd18537, 15'd18703, 15'd18868, 15'd19032, 15'd19195, 15'd19357,
    15'd19519, 15'd19680, 15'd19841, 15'd20000, 15'd20159, 15'd20317, 15'd20475, 15'd20631,
    15'd20787, 15'd20942, 15'd21096, 15'd21250, 15'd21403, 15'd21554, 15'd21705, 15'd21856,
    15'd22005, 15'd22154, 15'd22301, 15'd22448, 15'd22594, 15'd22739, 15'd22884, 15'd23027,
    15'd23170, 15'd23311, 15'd23452, 15'd23592, 15'd23731, 15'd23870, 15'd24007, 15'd24143,
    15'd24279, 15'd24413, 15'd24547, 15'd24680, 15'd24811, 15'd24942, 15'd25072, 15'd25201,
    15'd25329, 15'd25456, 15'd25582, 15'd25708, 15'd25832, 15'd25955, 15'd26077, 15'd26198,
    15'd26319, 15'd26438, 15'd26556, 15'd26674, 15'd26790, 15'd26905, 15'd27019, 15'd27133,
    15'd27245, 15'd27356, 15'd27466, 15'd27575, 15'd27683, 15'd27790, 15'd27896, 15'd28001,
    15'd28105, 15'd28208, 15'd28310, 15'd28411, 15'd28510, 15'd28609, 15'd28706, 15'd28803,
    15'd28898, 15'd28992, 15'd29085, 15'd29177, 15'd29268, 15'd29358, 15'd29447, 15'd29534,
    15'd29621, 15'd29706, 15'd29791, 15'd29874, 15'd29956, 15'd30037, 15'd30117, 15'd30195,
    15'd30273, 15'd30349, 15'd30424, 15'd30498, 15'd30571, 15'd30643, 15'd30714, 15'd30783,
    15'd30852, 15'd30919, 15'd30985, 15'd31050, 15'd31113, 15'd31176, 15'd31237, 15'd31297,
    15'd31356, 15'd31414, 15'd31470, 15'd31526, 15'd31580, 15'd31633, 15'd31685, 15'd31736,
    15'd31785, 15'd31833, 15'd31880, 15'd31926, 15'd31971, 15'd32014, 15'd32057, 15'd32098,
    15'd32137, 15'd32176, 15'd32213, 15'd32250, 15'd32285, 15'd32318, 15'd32351, 15'd32382,
    15'd32412, 15'd32441, 15'd32469, 15'd32495, 15'd32521, 15'd32545, 15'd32567, 15'd32589,
    15'd32609, 15'd32628, 15'd32646, 15'd32663, 15'd32678, 15'd32692, 15'd32705, 15'd32717,
    15'd32728, 15'd32737, 15'd32745, 15'd32752, 15'd32757, 15'd32761, 15'd32765, 15'd32766,
    15'd32767
  };

  logic [2:0]             vld_q;
  logic [ANGLE_W-1:0]     angle [2];
  logic [MAG_W-1:0]       mag_d [2];
  logic                   neg_d [2];
  logic [MAG_W-1:0]       mag_q [2];
  logic                   neg_q [2];
  logic [AMP_W-1:0]       umax_q;
  logic [PROD_W-1:0]      prod_q [2];
  logic                   neg2_q [2];
  phase_drive_t           drive_d [2];
  phase_drive_t           drive_q [2];

  // Phase A leads phase B by a quarter electrical turn
  assign angle[0] = angle_i + ANGLE_W'(SINE_QUARTER);
  assign angle[1] = angle_i;

  // Fold each angle onto the quarter wave and look up the magnitude
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [HALF_W-1:0] half_idx;
      logic [HALF_W-1:0] fold_idx;
      half_idx = angle[l][HALF_W-1:0];
      if (half_idx > HALF_W'(SINE_QUARTER)) begin
        fold_idx = HALF_W'(ANGLE_W'(SINE_ENTRIES / 2) - {1'b0, half_idx});
      end else begin
        fold_idx = half_idx;
      end
      neg_d[l] = (angle[l] > ANGLE_W'(SINE_ENTRIES / 2));
      mag_d[l] = QuarterSine[fold_idx];
    end
  end

  // Round the scaled sine toward zero magnitude for the positive half, up for the negative
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [PROD_W:0] up_sum;
      up_sum = {1'b0, prod_q[l]} + (PROD_W + 1)'((1 << Q_SHIFT) - 1);
      if (neg2_q[l] && (prod_q[l] != '0)) begin
        drive_d[l].positive = 1'b0;
        drive_d[l].level    = AMP_W'(up_sum >> Q_SHIFT);
      end else begin
        drive_d[l].positive = 1'b1;
        drive_d[l].level    = AMP_W'(prod_q[l] >> Q_SHIFT);
      end
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // Lookup, multiply and round stages
  always_ff @(posedge clk_i) begin
    umax_q <= umax_i;
    for (int l = 0; l < 2; l++) begin
      mag_q[l]   <= mag_d[l];
      neg_q[l]   <= neg_d[l];
      prod_q[l]  <= PROD_W'(umax_q) * PROD_W'(mag_q[l]);
      neg2_q[l]  <= neg_q[l];
      drive_q[l] <= drive_d[l];
    end
  end

  assign valid_o   = vld_q[2];
  assign phase_a_o = drive_q[0];
  assign phase_b_o = drive_q[1];

endmodule

>>> sv/closed_loop_stepper_commutator.sv
// Closed-loop stepper commutator top level: config registers, position and amplitude stages.
// Depends on clsc_pkg and clsc_coil_pair.
//
//   channel   | signals                                   | handshake
//   ----------+-------------------------------------------+---------------------------
//   sample in | raw_angle_i                               | start & !busy
//   config    | cfg_index_i, cfg_data_i                   | cfg_valid_i & cfg_ready_o
//   drive out | phase_a_positive_o/level_o, phase_b_...   | done_o strobe, one cycle
//
// One sample enters every cycle; busy is never raised and cfg_ready_o is always high.
// Each result appears on done_o after its sample has passed the ten register stages
// (offset, scale, error, lead, two amplitude multiplies, amplitude correct, sine
// lookup, coil multiply, rounding). The receiver cannot stall, so no
// stage ever holds. Reset clears the valid bits and restores register defaults.
module closed_loop_stepper_commutator #(
  parameter int SENSOR_BITS = clsc_pkg::SENSOR_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [SENSOR_BITS-1:0]          raw_angle_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [clsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [clsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            done_o,
  output logic                            phase_a_positive_o,
  output logic [clsc_pkg::AMP_W-1:0]      phase_a_level_o,
  output logic                            phase_b_positive_o,
  output logic [clsc_pkg::AMP_W-1:0]      phase_b_level_o
);
  import clsc_pkg::*;

  localparam int SCALE_W  = SENSOR_BITS + CUR_W;
  localparam int ERR_W    = CUR_W + 1;
  localparam int LEAD_W   = ANGLE_W + 1;
  localparam int LIM_W    = $clog2(MAX_LEAD + 1);
  localparam int SPAN_W   = AMP_W + CLAMP_W;
  localparam int Z_W      = SPAN_W - 9;
  localparam int RECIP_SH = 16;
  localparam int RECIP    = (1 << RECIP_SH) / 25;
  localparam int RPROD_W  = Z_W + 12;
  localparam int QUO_W    = RPROD_W - RECIP_SH;

  // Configuration registers
  logic [1:0]        drive_mode_q;
  logic [CUR_W-1:0]  target_position_q;
  logic [13:0]       sensor_offset_q;
  logic [AMP_W-1:0]  run_current_q;
  logic [AMP_W-1:0]  hold_min_q;
  logic [AMP_W-1:0]  hold_max_q;

  // Pipeline registers
  logic [6:0]             vld_q;
  logic [SENSOR_BITS-1:0] cal_q;
  logic [CUR_W-1:0]       cur_q;
  logic [CUR_W-1:0]       err_q;
  logic [CUR_W-1:0]       cur3_q;
  logic [ANGLE_W-1:0]     e4_q, e5_q, e6_q, e7_q;
  logic [AMP_W-1:0]       span_q;
  logic [CLAMP_W-1:0]     clamp_q;
  logic [Z_W-1:0]         z_q;
  logic [Z_W-1:0]         z6_q;
  logic [QUO_W-1:0]       q0_q;
  logic [AMP_W-1:0]       umax_q;

  logic [SENSOR_BITS-1:0] cal_d;
  logic [SCALE_W-1:0]     scale;
  logic [ERR_W-1:0]       err_sum;
  logic [CUR_W-1:0]       err_d;
  logic                   far_half;
  logic [CUR_W-1:0]       err_fold;
  logic [LIM_W-1:0]       lead_mag;
  logic [LEAD_W-1:0]      lead;
  logic [ANGLE_W-1:0]     e_d;
  logic [AMP_W-1:0]       span_d;
  logic [SPAN_W-1:0]      span_prod;
  logic [RPROD_W-1:0]     recip_prod;
  logic [Z_W-1:0]         times25;
  logic [Z_W-1:0]         rem;
  logic [QUO_W-1:0]       quo;
  logic [AMP_W-1:0]       umax_d;
  logic                   coil_valid;
  phase_drive_t           phase_a, phase_b;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Take a configuration transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_mode_q      <= MODE_OFF;
      target_position_q <= '0;
      sensor_offset_q   <= 14'd287;
      run_current_q     <= 13'd4000;
      hold_min_q        <= 13'd2000;
      hold_max_q        <= 13'd6000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DRIVE_MODE:  drive_mode_q      <= cfg_data_i[1:0];
        REG_TARGET_POS:  target_position_q <= cfg_data_i;
        REG_SENSOR_OFS:  sensor_offset_q   <= cfg_data_i[13:0];
        REG_RUN_CURRENT: run_current_q     <= cfg_data_i[AMP_W-1:0];
        REG_HOLD_MIN:    hold_min_q        <= cfg_data_i[AMP_W-1:0];
        REG_HOLD_MAX:    hold_max_q        <= cfg_data_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: remove sensor offset, wrapping within the sensor range
  assign cal_d = raw_angle_i - SENSOR_BITS'(sensor_offset_q);

  // Stage 2: scale to microsteps of one turn
  assign scale = SCALE_W'(cal_q) * SCALE_W'(TURN_USTEPS);

  // Stage 3: position error modulo one turn
  always_comb begin
    err_sum = {1'b0, target_position_q} + ERR_W'(TURN_USTEPS) - {1'b0, cur_q};
    if (err_sum >= ERR_W'(2 * TURN_USTEPS)) begin
      err_d = CUR_W'(err_sum - ERR_W'(2 * TURN_USTEPS));
    end else if (err_sum >= ERR_W'(TURN_USTEPS)) begin
      err_d = CUR_W'(err_sum - ERR_W'(TURN_USTEPS));
    end else begin
      err_d = CUR_W'(err_sum);
    end
  end

  // Stage 4: fold error, pick lead and electrical angle, clamp error for amplitude
  always_comb begin
    far_half = (err_q >= CUR_W'(HALF_TURN));
    err_fold = far_half ? CUR_W'(TURN_USTEPS - 1) - err_q : err_q;
    lead_mag = (err_fold > CUR_W'(MAX_LEAD)) ? LIM_W'(MAX_LEAD) : LIM_W'(err_fold);
    lead     = far_half ? LEAD_W'(SINE_ENTRIES) - LEAD_W'(lead_mag) : LEAD_W'(lead_mag);
    span_d   = (hold_max_q > hold_min_q) ? hold_max_q - hold_min_q : '0;
    case (drive_mode_q)
      MODE_RUN:  e_d = cur3_q[ANGLE_W-1:0] + ANGLE_W'(MAX_LEAD);
      MODE_HOLD: e_d = cur3_q[ANGLE_W-1:0] + lead[ANGLE_W-1:0];
      default:   e_d = '0;
    endcase
  end

  // Stage 5: span times clamped error, drop the power-of-two part of /12800
  assign span_prod = SPAN_W'(span_q) * SPAN_W'(clamp_q);

  // Stage 6: estimate the remaining /25 with a reciprocal, low by up to two
  assign recip_prod = RPROD_W'(z_q) * RPROD_W'(RECIP);

  // Stage 7: correct the estimate and select amplitude by mode
  always_comb begin
    times25 = (Z_W'(q0_q) << 4) + (Z_W'(q0_q) << 3) + Z_W'(q0_q);
    rem     = z6_q - times25;
    if (rem >= Z_W'(50)) begin
      quo = q0_q + QUO_W'(2);
    end else if (rem >= Z_W'(25)) begin
      quo = q0_q + QUO_W'(1);
    end else begin
      quo = q0_q;
    end
    case (drive_mode_q)
      MODE_RUN:  umax_d = run_current_q;
      MODE_HOLD: umax_d = hold_min_q + AMP_W'(quo);
      default:   umax_d = '0;
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], start && !busy};
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    cal_q   <= cal_d;
    cur_q   <= CUR_W'(scale >> SENSOR_BITS);
    err_q   <= err_d;
    cur3_q  <= cur_q;
    e4_q    <= e_d;
    span_q  <= span_d;
    clamp_q <= (err_fold > CUR_W'(QUARTER_TURN)) ? CLAMP_W'(QUARTER_TURN) : CLAMP_W'(err_fold);
    z_q     <= span_prod[SPAN_W-1:9];
    e5_q    <= e4_q;
    q0_q    <= recip_prod[RPROD_W-1:RECIP_SH];
    z6_q    <= z_q;
    e6_q    <= e5_q;
    umax_q  <= umax_d;
    e7_q    <= e6_q;
  end

  // Sine lookup and coil scaling for both phases
  clsc_coil_pair u_coils (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vld_q[6]),
    .angle_i   (e7_q),
    .umax_i    (umax_q),
    .valid_o   (coil_valid),
    .phase_a_o (phase_a),
    .phase_b_o (phase_b)
  );

  assign done_o             = coil_valid;
  assign phase_a_positive_o = phase_a.positive;
  assign phase_a_level_o    = phase_a.level;
  assign phase_b_positive_o = phase_b.positive;
  assign phase_b_level_o    = phase_b.level;

endmodule
